// ===== sv/fpas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_pkg
// Shared types and constants of the fixed-point attention score unit.
// ----------------------------------------------------------------------------
package fpas_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int MAX_HEAD_DIM_DEF  = 128;

	localparam int DATA_W     = 32;
	localparam int INDEX_W    = 7;
	localparam int HEAD_DIM_W = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [HEAD_DIM_W-1:0] HEAD_DIM_RESET = 8'd64;
	localparam logic [DATA_W-1:0]     SCALE_RESET    = 32'd65536;

	// Configuration register indexes.
	localparam logic REG_HEAD_DIM = 1'b0;
	localparam logic REG_SCALE    = 1'b1;

	// Operation codes on the input channel.
	localparam logic OP_LOAD_QUERY = 1'b0;
	localparam logic OP_KEY        = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_KEY,
		CMD_SKIP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [INDEX_W-1:0] index;
		logic [DATA_W-1:0]  value;
		logic               last;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_SCALE,
		ST_EMIT
	} back_state_t;

endpackage

// ===== sv/fpas_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fpas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/fpas_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_front
// Accepts input words and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module fpas_front
	import fpas_pkg::*;
#(
	parameter int MAX_HEAD_DIM = MAX_HEAD_DIM_DEF
) (
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [INDEX_W-1:0]  index,
	input  logic [DATA_W-1:0]   value,
	input  logic                last_row,
	input  logic                q_full,
	output logic                q_push,
	output cmd_t                q_data
);

	logic in_range;

	// Loads outside the query store are dropped without touching anything.
	assign in_range = (32'(index) < MAX_HEAD_DIM);
	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		q_data.index = index;
		q_data.value = value;
		q_data.last  = last_row;
		if (operation == OP_KEY) begin
			q_data.kind = CMD_KEY;
		end else if (in_range) begin
			q_data.kind = CMD_LOAD;
		end else begin
			q_data.kind = CMD_SKIP;
		end
	end

endmodule

// ===== sv/fpas_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module fpas_queue
	import fpas_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] fill_q;

	assign full     = (fill_q == CW'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

// ===== sv/fpas_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_back
// Executes queued commands: query store writes, multiply-accumulate over a
// key row, scaling and the output register.
// ----------------------------------------------------------------------------
module fpas_back
	import fpas_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int MAX_HEAD_DIM  = MAX_HEAD_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic              q_empty,
	input  cmd_t              q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] score,
	output logic              last_score
);

	localparam int AW = (MAX_HEAD_DIM > 1) ? $clog2(MAX_HEAD_DIM) : 1;
	localparam int CW = $clog2(MAX_HEAD_DIM + 1);

	back_state_t state_q, state_d;

	logic [HEAD_DIM_W-1:0] head_dim_q;
	logic [DATA_W-1:0]     scale_q;
	logic [DATA_W-1:0]     acc_q;
	logic [CW-1:0]         count_q;
	logic [DATA_W-1:0]     key_val_q;
	logic                  key_last_q;
	logic signed [63:0]    prod_q;
	logic                  out_valid_q;
	logic [DATA_W-1:0]     score_q;
	logic                  out_last_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_W-1:0]     ram_rdata;
	logic [31:0]           index_w;
	logic [CW-1:0]         len_w;
	logic [CW-1:0]         count_inc;
	logic                  row_done;
	logic signed [DATA_W-1:0] mult_a, mult_b;
	logic signed [63:0]    mult_p;
	logic [DATA_W-1:0]     prod_fx;
	logic [DATA_W-1:0]     acc_sum;
	logic                  out_load;

	fpas_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_HEAD_DIM)
	) u_query_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(q_data.value),
		.raddr(count_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign index_w   = 32'(q_data.index);
	assign ram_waddr = index_w[AW-1:0];

	// Effective row length: zero counts as one, large values saturate.
	always_comb begin
		if (head_dim_q == '0) begin
			len_w = CW'(1);
		end else if (32'(head_dim_q) > MAX_HEAD_DIM) begin
			len_w = CW'(MAX_HEAD_DIM);
		end else begin
			len_w = CW'(head_dim_q);
		end
	end

	assign count_inc = count_q + CW'(1);
	assign row_done  = (count_inc >= len_w);

	// One shared multiplier: key times query, then sum times scale.
	always_comb begin
		case (state_q)
			ST_SCALE: begin
				mult_a = signed'(acc_q);
				mult_b = signed'(scale_q);
			end
			default: begin
				mult_a = signed'(ram_rdata);
				mult_b = signed'(key_val_q);
			end
		endcase
	end

	assign mult_p  = mult_a * mult_b;
	assign prod_fx = prod_q[FRACTION_BITS +: DATA_W];
	assign acc_sum = acc_q + prod_fx;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty && q_data.kind == CMD_KEY) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = row_done ? ST_SCALE : ST_IDLE;
			ST_SCALE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop  = !q_empty;
				ram_we = !q_empty && (q_data.kind == CMD_LOAD);
			end
			ST_EMIT: out_load = !out_valid_q || out_ready;
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_dim_q <= HEAD_DIM_RESET;
			scale_q    <= SCALE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_HEAD_DIM: head_dim_q <= cfg_data[HEAD_DIM_W-1:0];
				REG_SCALE:    scale_q    <= cfg_data;
				default:      scale_q    <= scale_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_ACC) begin
				acc_q   <= acc_sum;
				count_q <= row_done ? '0 : count_inc;
			end else if (state_q == ST_SCALE) begin
				acc_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			key_val_q  <= q_data.value;
			key_last_q <= q_data.last;
		end
		if (state_q == ST_MUL || state_q == ST_SCALE) begin
			prod_q <= mult_p;
		end
		if (out_load) begin
			score_q    <= prod_fx;
			out_last_q <= key_last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign score      = score_q;
	assign last_score = out_last_q;

endmodule

// ===== sv/fixed_point_attention_scores.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_attention_scores
// Signed fixed-point attention scores: query store, key-row dot products and
// scaling, with a decoupled front end and back end.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake              | Words carried
//   --------+------------------------+-------------------------------------
//   in      | in_valid / in_ready    | operation, index, value, last_row
//   out     | out_valid / out_ready  | score, last_score
//   config  | cfg_write (no wait)    | cfg_index, cfg_data
//
// A query load is written to the store as it leaves the queue. A key element
// that does not finish its row goes through a store read, a multiply and an
// accumulate; the one that finishes it then uses the shared multiplier a
// second time for the scale, and the score is written to the output register.
// The two-entry queue keeps accepting words while the back end works.
// Reset is asynchronous and active low; there is no clearing pass. A stalled
// output holds its word and stops the back end only when a new score is ready.
//
module fixed_point_attention_scores
	import fpas_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int MAX_HEAD_DIM  = MAX_HEAD_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [DATA_W-1:0]  cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [INDEX_W-1:0] index,
	input  logic [DATA_W-1:0]  value,
	input  logic               last_row,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DATA_W-1:0]  score,
	output logic               last_score
);

	// Front end: classifies each word into a load, a key or a dropped load.
	logic q_full, q_push, q_pop, q_empty;
	cmd_t push_cmd, pop_cmd;

	fpas_front #(
		.MAX_HEAD_DIM(MAX_HEAD_DIM)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.index    (index),
		.value    (value),
		.last_row (last_row),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_cmd)
	);

	// The queue lets the input side run ahead of the multiply-accumulate.
	fpas_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (pop_cmd),
		.empty    (q_empty)
	);

	// Back end: query store, accumulator, row counter and output register.
	fpas_back #(
		.FRACTION_BITS(FRACTION_BITS),
		.MAX_HEAD_DIM (MAX_HEAD_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_data    (pop_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.score     (score),
		.last_score(last_score)
	);

endmodule

// ===== sv/fpas_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_checker
// Port-level checks of the attention score unit, bound to the top level.
// ----------------------------------------------------------------------------
module fpas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] score,
	input logic        last_score
);

	// An edge seen with reset held leaves no score offered afterwards.
	assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("score offered during reset");

	// Right after reset the queue is empty and the output register is free.
	assert property (@(posedge clk) $rose(arst_n) |-> in_ready && !out_valid)
		else $error("unit not empty after reset");

	// A score that is not taken stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(score) && $stable(last_score))
		else $error("stalled score changed");

endmodule

bind fixed_point_attention_scores fpas_checker u_checker (.*);

// ===== sim/tb_fixed_point_attention_scores.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_attention_scores
// Self-checking bench for the attention score unit. A queue of query loads
// and key words feeds a handshake driver. Every accepted word updates a
// local fixed-point copy of the query store and the row accumulator; with the
// copied registers, that copy predicts each score. A monitor compares every
// score with the oldest prediction. The run covers register extremes,
// changes of row length in the middle of a row, and several patterns of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_fixed_point_attention_scores;
	import fpas_pkg::*;

	// One word on the input channel.
	typedef struct {
		logic               op;
		logic [INDEX_W-1:0] idx;
		logic [DATA_W-1:0]  val;
		logic               last;
	} in_word_t;

	// One word on the output channel.
	typedef struct {
		logic [DATA_W-1:0] score;
		logic              last;
	} score_word_t;

	// Every input of the block holds a known value from time zero.
	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_write  = 1'b0;
	logic               cfg_index  = REG_HEAD_DIM;
	logic [DATA_W-1:0]  cfg_data   = '0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic               operation  = OP_LOAD_QUERY;
	logic [INDEX_W-1:0] index      = '0;
	logic [DATA_W-1:0]  value      = '0;
	logic               last_row   = 1'b0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [DATA_W-1:0]  score;
	logic               last_score;

	fixed_point_attention_scores dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.index      (index),
		.value      (value),
		.last_row   (last_row),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.score      (score),
		.last_score (last_score)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predicted state of the block. It changes only on words and register
	// writes that the block has actually taken at a rising edge.
	// ------------------------------------------------------------------------
	logic [DATA_W-1:0]     query_mem [MAX_HEAD_DIM_DEF];
	logic [DATA_W-1:0]     dot_acc      = '0;
	int unsigned           dot_pos      = 0;
	logic [HEAD_DIM_W-1:0] head_dim_reg = HEAD_DIM_RESET;
	logic [DATA_W-1:0]     scale_reg    = SCALE_RESET;
	score_word_t           scores_due [$];
	int                    fail_count   = 0;

	// Stimulus side: words waiting for the driver, plus a shadow of the row
	// position so that no key ever reads a query entry that was never loaded.
	in_word_t              in_words [$];
	in_word_t              next_word;
	bit                    in_taken     = 1'b0;
	logic [HEAD_DIM_W-1:0] gen_head     = HEAD_DIM_RESET;
	int unsigned           gen_pos      = 0;
	bit                    gen_loaded [MAX_HEAD_DIM_DEF];
	int                    gen_total    = 0;

	// Pacing knobs, in percent, and the long receiver hold-off in cycles.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	// Row length actually used: zero acts as one, and anything above the
	// store depth is clipped to the depth.
	function automatic int row_length(input logic [HEAD_DIM_W-1:0] hd);
		if (hd == 0)
			return 1;
		if (int'(hd) > MAX_HEAD_DIM_DEF)
			return MAX_HEAD_DIM_DEF;
		return int'(hd);
	endfunction

	// Signed fixed-point product: full 64-bit product, arithmetic shift by the
	// fraction width, and the low 32 bits kept, so large products wrap.
	function automatic logic [DATA_W-1:0] fx_mul(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		longint prod;
		prod = longint'($signed(a)) * longint'($signed(b));
		prod = prod >>> FRACTION_BITS_DEF;
		return prod[DATA_W-1:0];
	endfunction

	// Apply one accepted word. A query load only writes the store, even in
	// the middle of a row. A key word adds its product to the running dot
	// product, and the word that completes the row yields the scaled score.
	task automatic take_word(input logic op, input logic [INDEX_W-1:0] idx,
			input logic [DATA_W-1:0] val, input logic last);
		score_word_t s;
		if (op == OP_LOAD_QUERY) begin
			query_mem[idx] = val;
		end else begin
			dot_acc = dot_acc + fx_mul(query_mem[dot_pos], val);
			dot_pos++;
			if (dot_pos >= row_length(head_dim_reg)) begin
				s.score = fx_mul(dot_acc, scale_reg);
				s.last  = last;
				scores_due.push_back(s);
				dot_acc = '0;
				dot_pos = 0;
			end
		end
	endtask

	task automatic check_score();
		score_word_t want;
		if (scores_due.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("score %h last_score %b arrived with no score due", score, last_score);
		end else begin
			want = scores_due.pop_front();
			if (score !== want.score || last_score !== want.last) begin
				fail_count++;
				if (fail_count <= 10)
					$display("score mismatch: expected score %h last_score %b, got %h %b",
						want.score, want.last, score, last_score);
			end
		end
	endtask

	// Everything is sampled at the rising edge, before the block's own
	// nonblocking updates land, so the values seen are the ones it took.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write) begin
				if (cfg_index == REG_HEAD_DIM)
					head_dim_reg = cfg_data[HEAD_DIM_W-1:0];
				else
					scale_reg = cfg_data;
			end
			in_taken = in_valid && in_ready;
			if (in_taken)
				take_word(operation, index, value, last_row);
			if (out_valid && out_ready)
				check_score();
		end
	end

	// Input driver. A word stays on the port until it is taken; only then may
	// the next one replace it, or the port fall idle for a random gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_word = in_words.pop_front();
				operation <= next_word.op;
				index     <= next_word.idx;
				value     <= next_word.val;
				last_row  <= next_word.last;
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output receiver: random stalls, or a long hold-off when one is armed.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [DATA_W-1:0] pick_value();
		logic [DATA_W-1:0] corner [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
			32'hFFFF_FFFF, 32'h0001_0000};
		case ($urandom_range(3))
			0: return corner[$urandom_range(4)];
			// Small signed values around plus or minus two, so that sums stay
			// readable instead of always wrapping.
			1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_load(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
		in_word_t w;
		w.op   = OP_LOAD_QUERY;
		w.idx  = idx;
		w.val  = val;
		w.last = $urandom_range(1);
		in_words.push_back(w);
		gen_loaded[idx] = 1'b1;
		gen_total++;
	endtask

	// A key word. If the query entry it will meet was never loaded, a load of
	// that entry goes first. The index field is ignored for keys, so it is
	// random.
	task automatic queue_key(input logic [DATA_W-1:0] val, input logic last);
		in_word_t w;
		if (!gen_loaded[gen_pos])
			queue_load(INDEX_W'(gen_pos), pick_value());
		w.op   = OP_KEY;
		w.idx  = INDEX_W'($urandom_range(127));
		w.val  = val;
		w.last = last;
		in_words.push_back(w);
		gen_total++;
		gen_pos++;
		if (gen_pos >= row_length(gen_head))
			gen_pos = 0;
	endtask

	// Random traffic. Most of it is attention sequences: reload part of the
	// query row, then one to three full key rows, with last_row set on the
	// final row and an occasional load slipped into the middle of a row.
	// About one sequence in ten is noise: stray loads and loose keys that
	// leave a row half done.
	task automatic queue_traffic(input int n);
		int start;
		int len;
		int rows;
		start = gen_total;
		while (gen_total - start < n) begin
			len = row_length(gen_head);
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(4, 1)) begin
					if ($urandom_range(1))
						queue_load(INDEX_W'($urandom_range(127)), pick_value());
					else
						queue_key(pick_value(), $urandom_range(1));
				end
			end else begin
				repeat ($urandom_range(len))
					queue_load(INDEX_W'($urandom_range(len - 1)), pick_value());
				rows = $urandom_range(3, 1);
				for (int r = 0; r < rows; r++) begin
					repeat (len) begin
						if ($urandom_range(15) == 0)
							queue_load(INDEX_W'($urandom_range(127)), pick_value());
						queue_key(pick_value(), r == rows - 1);
					end
				end
			end
		end
	endtask

	// Register write, one cycle of write enable. The bench calls this only
	// while the block is idle.
	task automatic write_reg(input logic idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_HEAD_DIM)
			gen_head = data[HEAD_DIM_W-1:0];
	endtask

	task automatic write_head_dim(input logic [HEAD_DIM_W-1:0] hd);
		// Bits above the register width carry junk; the block must ignore them.
		write_reg(REG_HEAD_DIM, {24'($urandom()), hd});
	endtask

	// Wait until every word has been taken and every score has come out. A
	// trailing key that completes no row can still be in the back end at that
	// point, so the wait goes on long enough for the back end and the two-entry
	// queue in front of it to drain.
	task automatic settle();
		while (in_words.size() > 0 || in_valid || scores_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Rows of one element with the reset scale: the
		// largest and smallest values, so that their products wrap, a zero
		// key, and a load at the top index of the store.
		write_head_dim(8'd0);
		queue_load(7'd0, 32'h7FFF_FFFF);
		queue_key(32'h7FFF_FFFF, 1'b0);
		queue_key(32'h8000_0000, 1'b0);
		queue_load(7'd0, 32'h8000_0000);
		queue_key(32'h8000_0000, 1'b1);
		queue_key(32'h0000_0000, 1'b1);
		queue_load(7'd127, 32'hFFFF_FFFF);
		settle();

		// Rows of three with the most negative scale. Query entry 1 is
		// rewritten after the row has begun but before the row reaches it.
		write_head_dim(8'd3);
		write_reg(REG_SCALE, 32'h8000_0000);
		queue_load(7'd1, 32'h0001_0000);
		queue_load(7'd2, 32'hFFFF_0000);
		queue_key(32'h0003_0000, 1'b0);
		queue_load(7'd1, 32'h7FFF_FFFF);
		queue_key(32'h7FFF_FFFF, 1'b0);
		queue_key(32'h8000_0000, 1'b1);
		// Two thirds of a row, then the row length drops below the current
		// position: the next key must close the row.
		queue_key(pick_value(), 1'b0);
		queue_key(pick_value(), 1'b0);
		settle();
		write_head_dim(8'd1);
		queue_key(32'h0002_0000, 1'b1);
		settle();
		write_reg(REG_SCALE, 32'h7FFF_FFFF);
		queue_key(pick_value(), 1'b0);
		queue_key(32'hFFFF_FFFF, 1'b1);
		settle();

		// No idling. Each key closes a row, so scores pile up while the
		// receiver holds off for a long stretch and the block has to stall
		// its input.
		write_reg(REG_SCALE, pick_value());
		queue_traffic(70);
		@(posedge clk);
		hold_left = 150;
		settle();

		// Sender idle most of the time. Halfway through, the sender pauses
		// until every score is out.
		send_idle_pct = 59;
		write_head_dim(8'd4);
		write_reg(REG_SCALE, pick_value());
		queue_traffic(35);
		settle();
		queue_traffic(35);
		settle();

		// Receiver stalling most of the time.
		send_idle_pct  = 0;
		recv_stall_pct = 59;
		write_head_dim(8'd9);
		write_reg(REG_SCALE, pick_value());
		queue_traffic(70);
		settle();

		// Both sides idle now and then.
		send_idle_pct  = 18;
		recv_stall_pct = 18;
		write_head_dim(8'd5);
		write_reg(REG_SCALE, 32'hFFFF_FFFF);
		queue_traffic(70);
		settle();

		// Row length at the register maximum, clipped to the full store. One
		// whole row, which also fills every query entry not yet loaded.
		write_head_dim(8'd255);
		write_reg(REG_SCALE, SCALE_RESET);
		repeat (MAX_HEAD_DIM_DEF)
			queue_key(pick_value(), 1'b1);
		settle();

		if (fail_count == 0 && scores_due.size() == 0)
			$display("[fixed_point_attention_scores] OK");
		else
			$display("[fixed_point_attention_scores] ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this sequence.
	initial begin
		#4_000_000;
		$display("[fixed_point_attention_scores] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/fpas_pkg.sv
sv/fpas_ram.sv
sv/fpas_front.sv
sv/fpas_queue.sv
sv/fpas_back.sv
sv/fixed_point_attention_scores.sv
sv/fpas_checker.sv
sim/tb_fixed_point_attention_scores.sv
